/* hdl/cubic_bezier_ease_macros.svh */
// assertion macros used by the bezier easing rtl
`ifndef CUBIC_BEZIER_EASE_MACROS_SVH
`define CUBIC_BEZIER_EASE_MACROS_SVH

// implication in the same cycle
`define CBE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication into the next cycle
`define CBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/cbe_pkg.sv */
// types and constants for the bezier easing pipeline
package cbe_pkg;
   localparam int S_BITS    = 32;
   localparam int W_BITS    = 30;
   localparam int FRAC_BITS = 16;
   localparam int BW = S_BITS + 1;
   localparam int WW = 32;

   typedef enum logic [1:0] {
      REG_X1 = 2'd0,
      REG_Y1 = 2'd1,
      REG_X2 = 2'd2,
      REG_Y2 = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;
endpackage

/* hdl/cbe_eval.sv */
// three-stage evaluation of the bezier basis weights at the bound midpoint
module cbe_eval
   import cbe_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  stage_ctl_type       ctl,
   input  logic [BW-1:0]       lo,
   input  logic [BW-1:0]       hi,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                valid_out,
   output logic [WW-1:0]       w1,
   output logic [WW-1:0]       w2,
   output logic [WW-1:0]       w3,
   output logic [SIDE_W-1:0]   side_out
);
   logic [BW:0]          mid_sum;
   logic [W_BITS-1:0]    s_in;
   logic [W_BITS:0]      u_in;
   logic [W_BITS-1:0]    sa_ff, sb_ff;
   logic [W_BITS:0]      ua_ff, ub_ff;
   logic [W_BITS:0]      uu_ff;
   logic [W_BITS-1:0]    ss_ff;
   logic [2*W_BITS+1:0]  uu_prod, ss_prod;
   logic [WW-1:0]        uu3, u3;
   logic [WW+W_BITS-1:0] w1_prod, w2_prod;
   logic [2*W_BITS-1:0]  w3_prod;
   logic                 va_ff, vb_ff, vc_ff;
   logic [SIDE_W-1:0]    sida_ff, sidb_ff, sidc_ff;
   logic [WW-1:0]        w1_ff, w2_ff, w3_ff;

   assign mid_sum = {1'b0, lo} + {1'b0, hi};
   assign s_in    = mid_sum[S_BITS:S_BITS-W_BITS+1];
   assign u_in    = (W_BITS+1)'(1) << W_BITS;

   assign uu_prod = (2*W_BITS+2)'(ua_ff) * (2*W_BITS+2)'(ua_ff);
   assign ss_prod = (2*W_BITS+2)'(sa_ff) * (2*W_BITS+2)'(sa_ff);

   assign uu3     = WW'({uu_ff, 1'b0}) + WW'(uu_ff);
   assign u3      = WW'({ub_ff, 1'b0}) + WW'(ub_ff);
   assign w1_prod = (WW+W_BITS)'(uu3) * (WW+W_BITS)'(sb_ff);
   assign w2_prod = (WW+W_BITS)'(u3) * (WW+W_BITS)'(ss_ff);
   assign w3_prod = (2*W_BITS)'(ss_ff) * (2*W_BITS)'(sb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (ctl.advance) begin
         va_ff <= ctl.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         sa_ff   <= s_in;
         ua_ff   <= u_in - (W_BITS+1)'(s_in);
         sida_ff <= side_in;
         sb_ff   <= sa_ff;
         ub_ff   <= ua_ff;
         uu_ff   <= uu_prod[2*W_BITS:W_BITS];
         ss_ff   <= ss_prod[2*W_BITS-1:W_BITS];
         sidb_ff <= sida_ff;
         w1_ff   <= w1_prod[WW+W_BITS-1:W_BITS];
         w2_ff   <= w2_prod[WW+W_BITS-1:W_BITS];
         w3_ff   <= WW'(w3_prod[2*W_BITS-1:W_BITS]);
         sidc_ff <= sidb_ff;
      end
   end

   assign valid_out = vc_ff;
   assign w1        = w1_ff;
   assign w2        = w2_ff;
   assign w3        = w3_ff;
   assign side_out  = sidc_ff;
endmodule

/* hdl/cubic_bezier_ease.sv */
// each request runs through BISECT_STEPS bisection sections, then a final evaluation section
// throughput: one request per cycle while no response is stalled; each bisection step is its own five-stage section
// a stalled response holds the whole pipeline in place
// reset: synchronous, clears all stage valid bits and loads the default control points
module cubic_bezier_ease
   import cbe_pkg::*;
#(
   parameter int BISECT_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [16:0]        req_progress,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [18:0] rsp_eased,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [18:0]        csr_data
);
`include "cubic_bezier_ease_macros.svh"

   localparam int XW     = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
   localparam int SUM_W  = WW + XW + 2;
   localparam int SIDE_W = 2 * BW + 17;
   localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;

   logic [16:0]        x1_ff, x2_ff;
   logic signed [18:0] y1_ff, y2_ff;
   logic               advance;

   logic [BW-1:0] lo_c [0:BISECT_STEPS];
   logic [BW-1:0] hi_c [0:BISECT_STEPS];
   logic [16:0]   t_c  [0:BISECT_STEPS];
   logic          v_c  [0:BISECT_STEPS];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= 17'd16384;
         y1_ff <= 19'sd0;
         x2_ff <= 17'd49152;
         y2_ff <= 19'sd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_X1:  x1_ff <= csr_data[16:0];
            REG_Y1:  y1_ff <= csr_data;
            REG_X2:  x2_ff <= csr_data[16:0];
            REG_Y2:  y2_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign lo_c[0] = '0;
   assign hi_c[0] = BW'(1) << S_BITS;
   assign t_c[0]  = (XW'(req_progress) > ONE) ? ONE[16:0] : req_progress;
   assign v_c[0]  = req_valid;

   for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
      stage_ctl_type   ctl;
      logic            ev_valid;
      logic [WW-1:0]   w1, w2, w3;
      logic [SIDE_W-1:0] side;
      logic [BW-1:0]   lo_d_ff, hi_d_ff, lo_e_ff, hi_e_ff;
      logic [16:0]     t_d_ff, t_e_ff;
      logic            v_d_ff, v_e_ff;
      logic [SUM_W-1:0] p1_ff, p2_ff, p3_ff;
      logic [SUM_W-1:0] xs, thr;
      logic [BW:0]      mid_sum;
      logic [BW-1:0]    mid;
      logic             below;

      assign ctl = {advance, v_c[k]};

      cbe_eval #(.SIDE_W(SIDE_W)) u_eval (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .lo        (lo_c[k]),
         .hi        (hi_c[k]),
         .side_in   ({lo_c[k], hi_c[k], t_c[k]}),
         .valid_out (ev_valid),
         .w1        (w1),
         .w2        (w2),
         .w3        (w3),
         .side_out  (side)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            v_d_ff <= 1'b0;
            v_e_ff <= 1'b0;
         end else if (advance) begin
            v_d_ff <= ev_valid;
            v_e_ff <= v_d_ff;
         end
      end

      assign xs      = p1_ff + p2_ff + p3_ff;
      assign thr     = SUM_W'(t_d_ff) << W_BITS;
      assign below   = xs < thr;
      assign mid_sum = {1'b0, lo_d_ff} + {1'b0, hi_d_ff};
      assign mid     = mid_sum[BW:1];

      always_ff @(posedge clock) begin
         if (advance) begin
            p1_ff   <= SUM_W'(w1) * SUM_W'(x1_ff);
            p2_ff   <= SUM_W'(w2) * SUM_W'(x2_ff);
            p3_ff   <= SUM_W'(w3) << FRAC_BITS;
            lo_d_ff <= side[SIDE_W-1:BW+17];
            hi_d_ff <= side[BW+16:17];
            t_d_ff  <= side[16:0];
            lo_e_ff <= below ? mid : lo_d_ff;
            hi_e_ff <= below ? hi_d_ff : mid;
            t_e_ff  <= t_d_ff;
         end
      end

      assign lo_c[k+1] = lo_e_ff;
      assign hi_c[k+1] = hi_e_ff;
      assign t_c[k+1]  = t_e_ff;
      assign v_c[k+1]  = v_e_ff;
   end

   stage_ctl_type      fin_ctl;
   logic               fin_valid;
   logic [WW-1:0]      fw1, fw2, fw3;
   logic [2*BW-1:0]    fin_side;
   logic               vd_ff, out_valid_ff;
   logic signed [SUM_W:0] q1_ff, q2_ff, q3_ff;
   logic signed [SUM_W:0] ysum, yshift;
   logic signed [18:0]  eased_ff, eased_in;

   assign fin_ctl = {advance, v_c[BISECT_STEPS]};

   cbe_eval #(.SIDE_W(2 * BW)) u_final (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fin_ctl),
      .lo        (lo_c[BISECT_STEPS]),
      .hi        (hi_c[BISECT_STEPS]),
      .side_in   ({lo_c[BISECT_STEPS], hi_c[BISECT_STEPS]}),
      .valid_out (fin_valid),
      .w1        (fw1),
      .w2        (fw2),
      .w3        (fw3),
      .side_out  (fin_side)
   );

   assign ysum   = q1_ff + q2_ff + q3_ff;
   assign yshift = ysum >>> W_BITS;

   always_comb begin
      if (yshift > (SUM_W+1)'(262143)) begin
         eased_in = 19'sh3FFFF;
      end else if (yshift < -(SUM_W+1)'(262144)) begin
         eased_in = 19'sh40000;
      end else begin
         eased_in = yshift[18:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         vd_ff        <= fin_valid;
         out_valid_ff <= vd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff    <= $signed({1'b0, SUM_W'(fw1)}) * (SUM_W+1)'(y1_ff);
         q2_ff    <= $signed({1'b0, SUM_W'(fw2)}) * (SUM_W+1)'(y2_ff);
         q3_ff    <= $signed({1'b0, SUM_W'(fw3) << FRAC_BITS});
         eased_ff <= eased_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_eased = eased_ff;

   // bounds stay ordered through the search
   `CBE_ASSERT_SAME(a_bounds_ordered, clock, reset, fin_valid,
      fin_side[2*BW-1:BW] < fin_side[BW-1:0])
   // a stall freezes the tail of the pipeline
   `CBE_ASSERT_NEXT(a_stall_holds, clock, reset, !advance,
      $stable(vd_ff) && $stable(fin_valid))
   // a response comes only from the stage before it or is still held
   `CBE_ASSERT_SAME(a_rsp_source, clock, reset, rsp_valid,
      $past(vd_ff) || $past(rsp_valid))
endmodule

/* dv/cubic_bezier_ease_test.sv */
// self-checking testbench for the cubic bezier easing pipeline
module cubic_bezier_ease_test
   import cbe_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 5 * 24 + 5;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [16:0]        req_progress = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [18:0] rsp_eased;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [18:0]        csr_data = '0;

   cubic_bezier_ease dut (.*);

   always #5 clock = ~clock;

   logic [16:0]        progress_queue[$];
   logic signed [18:0] eased_queue[$];
   int                 n_pushed = 0;
   int                 n_taken = 0;
   int                 mismatches = 0;
   int                 send_idle_pct = 16;
   int                 recv_idle_pct = 75;
   int                 rsp_hold_cycles = 0;
   logic               req_taken = 1'b0;

   longint unsigned    cx1 = 16384;
   longint unsigned    cx2 = 49152;
   longint             cy1 = 0;
   longint             cy2 = 65536;

   function automatic void bezier_weights(input longint unsigned s32,
                                          output longint unsigned w1,
                                          output longint unsigned w2,
                                          output longint unsigned w3);
      longint unsigned s, u, uu, ss;
      s  = s32 >> 2;
      u  = (64'd1 << 30) - s;
      uu = (u * u) >> 30;
      ss = (s * s) >> 30;
      w1 = (64'd3 * uu * s) >> 30;
      w2 = (64'd3 * u * ss) >> 30;
      w3 = (ss * s) >> 30;
   endfunction

   function automatic logic signed [18:0] eased_value(input logic [16:0] progress);
      longint unsigned t, lo, hi, mid, w1, w2, w3, xs;
      longint          y;
      t  = progress;
      lo = 0;
      hi = 64'd1 << 32;
      if (t > 65536) t = 65536;
      for (int i = 0; i < 24; i++) begin
         mid = (lo + hi) >> 1;
         bezier_weights(mid, w1, w2, w3);
         xs = w1 * cx1 + w2 * cx2 + (w3 << 16);
         if (xs < (t << 30)) lo = mid;
         else hi = mid;
      end
      bezier_weights((lo + hi) >> 1, w1, w2, w3);
      y = longint'(w1) * cy1 + longint'(w2) * cy2 + longint'(w3 << 16);
      y = y >>> 30;
      if (y > 262143) y = 262143;
      if (y < -262144) y = -262144;
      return y[18:0];
   endfunction

   // request driver
   always @(negedge clock) begin
      if (req_valid && !req_taken) begin
      end else if (progress_queue.size() > 0 && !reset &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_valid    <= 1'b1;
         req_progress <= progress_queue.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response acceptor
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [18:0] want;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         eased_queue.insert(eased_queue.size(), eased_value(req_progress));
         n_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (eased_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response eased=%0d", rsp_eased);
         end else begin
            want = eased_queue.pop_front();
            if (want !== rsp_eased) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("eased mismatch: expected %0d actual %0d", want, rsp_eased);
            end
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [18:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         REG_X1: cx1 = value[16:0];
         REG_Y1: cy1 = longint'($signed(value));
         REG_X2: cx2 = value[16:0];
         REG_Y2: cy2 = longint'($signed(value));
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_progress(input logic [16:0] p);
      progress_queue.insert(progress_queue.size(), p);
      n_pushed++;
   endtask

   task automatic drain;
      while (progress_queue.size() > 0 || n_taken != n_pushed || eased_queue.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [16:0] random_progress;
      case ($urandom_range(9))
         0: return 17'($urandom_range(131071));
         1: return $urandom_range(1) ? 17'd0 : 17'd65536;
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset control points
      add_progress(17'd0);
      add_progress(17'd1);
      add_progress(17'd32767);
      add_progress(17'd32768);
      add_progress(17'd65535);
      add_progress(17'd65536);
      add_progress(17'd65537);
      add_progress(17'h1FFFF);
      add_progress(17'h0AAAA);
      add_progress(17'h15555);
      drain();

      // directed, extreme control points
      write_reg(REG_X1, 19'd0);
      write_reg(REG_Y1, -19'sd65536);
      write_reg(REG_X2, 19'd65536);
      write_reg(REG_Y2, 19'd131072);
      add_progress(17'd0);
      add_progress(17'd16384);
      add_progress(17'd49152);
      add_progress(17'd65536);
      add_progress(17'h1FFFF);
      drain();
      write_reg(REG_X1, 19'd65536);
      write_reg(REG_Y1, 19'd131072);
      write_reg(REG_X2, 19'd0);
      write_reg(REG_Y2, -19'sd65536);
      add_progress(17'd1);
      add_progress(17'd32768);
      add_progress(17'd65535);
      drain();
      write_reg(REG_X1, 19'h7FFFF);
      write_reg(REG_Y1, 19'h3FFFF);
      write_reg(REG_X2, 19'h7FFFF);
      write_reg(REG_Y2, 19'h40000);
      add_progress(17'd10000);
      add_progress(17'd40000);
      add_progress(17'd65536);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 16;
            recv_idle_pct = 75;
         end else if (phase < 6) begin
            send_idle_pct = 75;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase % 4 == 3) begin
            write_reg(REG_X1, 19'd16384);
            write_reg(REG_Y1, 19'd0);
            write_reg(REG_X2, 19'd49152);
            write_reg(REG_Y2, 19'd65536);
         end else begin
            write_reg(REG_X1, 19'($urandom_range(3) == 0 ? $urandom_range(524287)
                                                          : $urandom_range(65536)));
            write_reg(REG_Y1, 19'($urandom_range(3) == 0 ? $urandom_range(524287)
                                                          : $urandom_range(196608) - 65536));
            write_reg(REG_X2, 19'($urandom_range(3) == 0 ? $urandom_range(524287)
                                                          : $urandom_range(65536)));
            write_reg(REG_Y2, 19'($urandom_range(3) == 0 ? $urandom_range(524287)
                                                          : $urandom_range(196608) - 65536));
         end
         if (phase == 1 || phase == 6) rsp_hold_cycles = 400;
         for (int i = 0; i < 60; i++) begin
            add_progress(random_progress());
            // in phase 4 the sender waits once, mid phase, for the pipeline to empty
            if (phase == 4 && i == 30) begin
               while (progress_queue.size() > 0 || n_taken != n_pushed ||
                      eased_queue.size() > 0)
                  @(posedge clock);
            end
         end
         drain();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && eased_queue.size() == 0) begin
         $display("cubic_bezier_ease_test: PASS");
      end else begin
         $display("cubic_bezier_ease_test: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("cubic_bezier_ease_test: FAIL");
      $finish;
   end
endmodule
